// File: src/ghdc_pkg.sv
// Shared types, constants and register codes for the gyro heading drift compensator.
`default_nettype none

package ghdc_pkg;

  // Stream field and payload widths; the payloads are padded to whole bytes.
  localparam int RATE_W      = 19;
  localparam int HEAD_W      = 22;
  localparam int YAW_W       = 20;
  localparam int DRIFT_W     = 22;
  localparam int IN_DATA_W   = 64;
  localparam int OUT_DATA_W  = 72;

  // Configuration port.
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int LIMIT_W     = 18;
  localparam int MIN_W       = 24;

  localparam int COUNT_WIDTH_DEF = 24;

  // Heading magnitude fits in 21 bits, so the divider runs 21 steps.
  localparam int DIV_STEPS   = 21;

  localparam logic signed [22:0] HALF_TURN = 23'sd1800000;
  localparam logic signed [22:0] FULL_TURN = 23'sd3600000;
  localparam logic signed [22:0] RATE_MAX  = 23'sd402000;

  localparam logic signed [RATE_W-1:0] Z_OFFSET_RST  = '0;
  localparam logic [LIMIT_W-1:0]       STILL_LIM_RST = 18'd150;
  localparam logic [LIMIT_W-1:0]       DEADBAND_RST  = 18'd30;
  localparam logic [LIMIT_W-1:0]       ACCEPT_RST    = 18'd10;
  localparam logic [MIN_W-1:0]         MIN_INT_RST   = 24'd3000;
  localparam logic [MIN_W-1:0]         MIN_STILL_RST = 24'd300;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_Z_OFFSET  = 3'd0,
    REG_STILL_LIM = 3'd1,
    REG_DEADBAND  = 3'd2,
    REG_ACCEPT    = 3'd3,
    REG_MIN_INT   = 3'd4,
    REG_MIN_STILL = 3'd5
  } cfg_reg_t;

endpackage

`default_nettype wire

// File: src/gyro_heading_drift_compensator.sv
// Gyro yaw integrator with zero-rate drift estimation, built around a serial divider.
// One gyro sample in, one result out. A sample is taken only while the block is idle;
// it then runs the check, compute and output states, plus the divider states when a
// drift estimate is due: heading / samples_since_zero comes from a restoring divider
// that yields one quotient bit per cycle. A finished result sits in the output
// register, so the next sample is taken while the previous result waits to be read;
// a new result is held back, and the input with it, until that register is free.
// The user must write configuration registers only while idle; it is not enforced.
`default_nettype none

module gyro_heading_drift_compensator #(
  parameter int COUNT_WIDTH = ghdc_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // rate_x [18:0], rate_y [37:19], rate_z [56:38], zero fill above
  input  wire logic [ghdc_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // heading [21:0], yaw_rate [41:22], drift_estimate [63:42], is_still [64],
  // rezeroed [65], zero fill above
  output logic [ghdc_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic                            cfg_we,
  input  wire logic [ghdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ghdc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ghdc_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > MIN_W) ? COUNT_WIDTH : MIN_W;
  localparam int STEP_W = $clog2(DIV_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_DFIN,
    S_COMP,
    S_OUT
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic signed [RATE_W-1:0] z_offset_r;
  logic [LIMIT_W-1:0]       still_lim_r;
  logic [LIMIT_W-1:0]       deadband_r;
  logic [LIMIT_W-1:0]       accept_r;
  logic [MIN_W-1:0]         min_int_r;
  logic [MIN_W-1:0]         min_still_r;

  // Persistent state.
  logic signed [HEAD_W-1:0]  heading_r;
  logic signed [DRIFT_W-1:0] drift_r;
  logic [COUNT_WIDTH-1:0]    ssz_r;
  logic [COUNT_WIDTH-1:0]    still_run_r;

  // Per-sample working registers.
  logic signed [RATE_W-1:0] rx_r;
  logic signed [RATE_W-1:0] ry_r;
  logic signed [YAW_W-1:0]  rz_r;
  logic                     still_r;
  logic                     rezero_r;
  logic signed [YAW_W-1:0]  rate_r;

  // Divider.
  logic [COUNT_WIDTH-1:0]   rem_r;
  logic [DIV_STEPS-1:0]     dvd_r;
  logic [DIV_STEPS-1:0]     quo_r;
  logic                     neg_r;
  logic [STEP_W-1:0]        step_r;

  logic [RATE_W-1:0]        mag_x;
  logic [RATE_W-1:0]        mag_y;
  logic [YAW_W-1:0]         mag_z;
  logic                     still_nxt;
  logic [COUNT_WIDTH-1:0]   ssz_nxt;
  logic [COUNT_WIDTH-1:0]   still_run_nxt;
  logic                     est_go;
  logic [HEAD_W-1:0]        head_mag;
  logic [COUNT_WIDTH:0]     div_shift;
  logic [COUNT_WIDTH:0]     div_diff;
  logic                     div_ge;
  logic signed [22:0]       rate_sum;
  logic signed [22:0]       rate_sat;
  logic [22:0]              rate_mag;
  logic signed [YAW_W-1:0]  rate_nxt;
  logic signed [22:0]       head_sum;
  logic signed [22:0]       head_wrap;
  logic signed [HEAD_W-1:0] heading_nxt;
  logic                     out_free;

  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_tvalid || out_tready;

  always_comb begin
    mag_x = rx_r[RATE_W-1] ? RATE_W'(-rx_r) : RATE_W'(rx_r);
    mag_y = ry_r[RATE_W-1] ? RATE_W'(-ry_r) : RATE_W'(ry_r);
    mag_z = rz_r[YAW_W-1] ? YAW_W'(-rz_r) : YAW_W'(rz_r);
    still_nxt = (mag_x < {1'b0, still_lim_r}) && (mag_y < {1'b0, still_lim_r}) &&
                (mag_z < {2'b00, still_lim_r});

    ssz_nxt       = (ssz_r == '1) ? ssz_r : ssz_r + 1'b1;
    still_run_nxt = (still_run_r == '1) ? still_run_r : still_run_r + 1'b1;
    est_go = still_nxt &&
             (CMP_W'(ssz_nxt) >= CMP_W'(min_int_r)) &&
             (CMP_W'(still_run_nxt) >= CMP_W'(min_still_r));

    head_mag = heading_r[HEAD_W-1] ? HEAD_W'(-heading_r) : HEAD_W'(heading_r);

    // One restoring step: bring down the next dividend bit, subtract if it fits.
    div_shift = {rem_r, dvd_r[DIV_STEPS-1]};
    div_diff  = div_shift - {1'b0, ssz_r};
    div_ge    = (div_shift >= {1'b0, ssz_r});

    rate_sum = 23'(rz_r) - 23'(drift_r);
    if (rate_sum > RATE_MAX) begin
      rate_sat = RATE_MAX;
    end else if (rate_sum < -RATE_MAX) begin
      rate_sat = -RATE_MAX;
    end else begin
      rate_sat = rate_sum;
    end
    rate_mag = rate_sat[22] ? 23'(-rate_sat) : 23'(rate_sat);
    rate_nxt = (rate_mag < {5'b0, deadband_r}) ? '0 : rate_sat[YAW_W-1:0];

    head_sum = 23'(heading_r) + 23'(rate_r);
    if (head_sum >= HALF_TURN) begin
      head_wrap = head_sum - FULL_TURN;
    end else if (head_sum < -HALF_TURN) begin
      head_wrap = head_sum + FULL_TURN;
    end else begin
      head_wrap = head_sum;
    end
    heading_nxt = head_wrap[HEAD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_tvalid  <= 1'b0;
      z_offset_r  <= Z_OFFSET_RST;
      still_lim_r <= STILL_LIM_RST;
      deadband_r  <= DEADBAND_RST;
      accept_r    <= ACCEPT_RST;
      min_int_r   <= MIN_INT_RST;
      min_still_r <= MIN_STILL_RST;
      heading_r   <= '0;
      drift_r     <= '0;
      ssz_r       <= '0;
      still_run_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_Z_OFFSET:  z_offset_r  <= cfg_wdata[RATE_W-1:0];
          REG_STILL_LIM: still_lim_r <= cfg_wdata[LIMIT_W-1:0];
          REG_DEADBAND:  deadband_r  <= cfg_wdata[LIMIT_W-1:0];
          REG_ACCEPT:    accept_r    <= cfg_wdata[LIMIT_W-1:0];
          REG_MIN_INT:   min_int_r   <= cfg_wdata[MIN_W-1:0];
          REG_MIN_STILL: min_still_r <= cfg_wdata[MIN_W-1:0];
          default: ;
        endcase
      end

      // In S_OUT the output register is reloaded in the same cycle instead.
      if (out_tvalid && out_tready && (state_r != S_OUT)) begin
        out_tvalid <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            rx_r    <= in_tdata[18:0];
            ry_r    <= in_tdata[37:19];
            rz_r    <= YAW_W'($signed(in_tdata[56:38])) - YAW_W'(z_offset_r);
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          still_r     <= still_nxt;
          rezero_r    <= 1'b0;
          ssz_r       <= ssz_nxt;
          still_run_r <= still_nxt ? still_run_nxt : '0;
          if (est_go) begin
            rem_r   <= '0;
            quo_r   <= '0;
            dvd_r   <= head_mag[DIV_STEPS-1:0];
            neg_r   <= heading_r[HEAD_W-1];
            step_r  <= '0;
            state_r <= S_DIV;
          end else begin
            state_r <= S_COMP;
          end
        end
        S_DIV: begin
          rem_r  <= div_ge ? div_diff[COUNT_WIDTH-1:0] : div_shift[COUNT_WIDTH-1:0];
          quo_r  <= {quo_r[DIV_STEPS-2:0], div_ge};
          dvd_r  <= {dvd_r[DIV_STEPS-2:0], 1'b0};
          step_r <= step_r + 1'b1;
          if (step_r == LAST_STEP) begin
            state_r <= S_DFIN;
          end
        end
        S_DFIN: begin
          // The quotient takes the sign of the heading (truncation toward zero).
          drift_r <= neg_r ? -DRIFT_W'(quo_r) : DRIFT_W'(quo_r);
          if (quo_r < DIV_STEPS'(accept_r)) begin
            heading_r   <= '0;
            ssz_r       <= '0;
            still_run_r <= '0;
            rezero_r    <= 1'b1;
          end
          state_r <= S_COMP;
        end
        S_COMP: begin
          rate_r  <= rate_nxt;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            heading_r  <= heading_nxt;
            out_tdata  <= {6'b0, rezero_r, still_r, drift_r, rate_r, heading_nxt};
            out_tvalid <= 1'b1;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // A sample is taken only once until its result has been built.
  a_one_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a sample is in progress");

  // Rezero only happens on a still sample.
  a_rezero_still: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[65]) |-> out_tdata[64])
    else $error("rezero reported on a moving sample");

  // The reported heading stays inside one turn.
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (($signed(out_tdata[21:0]) >= -HALF_TURN) &&
                    ($signed(out_tdata[21:0]) < HALF_TURN)))
    else $error("heading out of range");

  // The divider never runs while its divisor is zero.
  a_div_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (ssz_r != '0))
    else $error("drift division by zero count");
`endif

endmodule

`default_nettype wire
